### src/icrc_pkg.sv
// ----------------------------------------------------------------------------
// icrc_pkg
// Types and constants shared by the invite code radix codec modules.
// ----------------------------------------------------------------------------
`default_nettype none

package icrc_pkg;

    // Fixed sizes of the codec
    localparam int unsigned ROLE_DIGITS    = 13;
    localparam int unsigned MAX_CODE_CHARS = 11;
    localparam int unsigned SCRAMBLE_SHIFT = 18;
    localparam int unsigned WORK_W         = 64;
    localparam int unsigned REV_W          = 47;
    localparam int unsigned CNT_W          = 4;
    localparam int unsigned DIGIT_W        = 6;
    localparam int unsigned BITS_PER_CYC   = 8;

    // Operation and result kind codes
    localparam logic OP_ENCODE   = 1'b0;
    localparam logic OP_DECODE   = 1'b1;
    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_ID     = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [43:0] role_id;
        logic [7:0]  code_char;
        logic        last_char;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [6:0]  out_char;
        logic [46:0] decoded_id;
        logic        last;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // item accepted this cycle
        logic b62_start;  // load reversed value, shifted, as base-62 dividend
        logic div_step;   // run one slice of the constant divider
        logic div_first;  // first slice: remainder starts at zero
        logic div62;      // divisor 62, else 10
        logic rev_acc;    // fold remainder into reversed value
        logic b62_store;  // store remainder as next base-62 digit
        logic emit;       // load next code character into the output register
        logic dec_out;    // load decoded identifier into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_dec;     // item on the input is a decode character
        logic in_last;    // item on the input ends a code
        logic job_dec;    // current job is a decode
        logic work_zero;  // dividend register is zero
        logic dcnt_lim;   // encode reversal has seen all its digits
        logic dcnt_one;   // one code character left to emit
        logic out_free;   // output register can take an item
    } t_sts;

endpackage

`default_nettype wire

### src/icrc_ctrl.sv
// ----------------------------------------------------------------------------
// icrc_ctrl
// Sequencer of the codec: reversal, base-62 split and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module icrc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire icrc_pkg::t_sts  i_sts,
    output icrc_pkg::t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_REV_CHK = 3'd1;
    localparam logic [2:0] S_REV_DIV = 3'd2;
    localparam logic [2:0] S_REV_ACC = 3'd3;
    localparam logic [2:0] S_B62_DIV = 3'd4;
    localparam logic [2:0] S_B62_ST  = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;
    localparam logic [2:0] S_DEC_OUT = 3'd7;

    localparam logic [2:0] STEP_LAST = 3'(icrc_pkg::WORK_W / icrc_pkg::BITS_PER_CYC - 1);

    logic [2:0] r_state, n_state;
    logic [2:0] r_step, n_step;

    // Take items only between jobs
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.in_dec || i_sts.in_last) begin
                        n_state = S_REV_CHK;
                    end
                end
            end
            S_REV_CHK: begin
                if (i_sts.work_zero || i_sts.dcnt_lim) begin
                    if (i_sts.job_dec) begin
                        n_state = S_DEC_OUT;
                    end else begin
                        o_cmd.b62_start = 1'b1;
                        n_state         = S_B62_DIV;
                    end
                end else begin
                    n_state = S_REV_DIV;
                end
                n_step = '0;
            end
            S_REV_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_step == '0);
                n_step          = r_step + 3'd1;
                if (r_step == STEP_LAST) begin
                    n_state = S_REV_ACC;
                end
            end
            S_REV_ACC: begin
                o_cmd.rev_acc = 1'b1;
                n_state       = S_REV_CHK;
            end
            S_B62_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_step == '0);
                o_cmd.div62     = 1'b1;
                n_step          = r_step + 3'd1;
                if (r_step == STEP_LAST) begin
                    n_state = S_B62_ST;
                end
            end
            S_B62_ST: begin
                o_cmd.b62_store = 1'b1;
                n_step          = '0;
                n_state         = i_sts.work_zero ? S_EMIT : S_B62_DIV;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.dcnt_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DEC_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.dec_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

### src/icrc_dpath.sv
// ----------------------------------------------------------------------------
// icrc_dpath
// Datapath of the codec: decode accumulator, constant divider, digit buffer
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module icrc_dpath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire icrc_pkg::t_cmd  i_cmd,
    output icrc_pkg::t_sts       o_sts,
    input  wire icrc_pkg::t_in   i_in_data,
    input  wire logic            i_out_stall,
    output logic                 o_out_valid,
    output icrc_pkg::t_out       o_out_data
);

    localparam int unsigned W  = icrc_pkg::WORK_W;
    localparam int unsigned RW = icrc_pkg::REV_W;
    localparam int unsigned CW = icrc_pkg::CNT_W;
    localparam int unsigned DW = icrc_pkg::DIGIT_W;

    function automatic logic [DW-1:0] ascii_to_digit(input logic [7:0] c);
        if (c >= 8'd48 && c <= 8'd57) begin
            return DW'(c - 8'd48);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            return DW'(c - 8'd87);
        end else if (c >= 8'd65 && c <= 8'd90) begin
            return DW'(c - 8'd29);
        end
        return '0;
    endfunction

    function automatic logic [6:0] digit_to_ascii(input logic [DW-1:0] d);
        if (d < 6'd10) begin
            return 7'(d) + 7'd48;
        end else if (d < 6'd36) begin
            return 7'(d) + 7'd87;
        end
        return 7'(d) + 7'd29;
    endfunction

    logic [W-1:0]  r_acc;
    logic [CW-1:0] r_count;
    logic [W-1:0]  r_work;
    logic [DW-1:0] r_rem;
    logic [RW-1:0] r_rev;
    logic [CW-1:0] r_dcnt;
    logic          r_job_dec;
    logic [DW-1:0] r_buf [icrc_pkg::MAX_CODE_CHARS];
    logic          r_out_valid;
    icrc_pkg::t_out r_out;

    logic [W-1:0]  n_acc;
    logic [W-1:0]  n_work;
    logic [DW-1:0] n_rem;
    logic [CW-1:0] emit_idx;

    // Fold one character: acc * 62 + digit, wrapping
    assign n_acc = (r_acc << 6) - (r_acc << 1) + W'(ascii_to_digit(i_in_data.code_char));

    // One slice of restoring division by 10 or 62
    always_comb begin
        logic [DW:0]   t;
        logic [DW:0]   dv;
        logic [DW-1:0] rem;
        logic [W-1:0]  wk;
        dv  = i_cmd.div62 ? 7'd62 : 7'd10;
        rem = i_cmd.div_first ? '0 : r_rem;
        wk  = r_work;
        for (int i = 0; i < icrc_pkg::BITS_PER_CYC; i++) begin
            t = {rem, wk[W-1]};
            wk = {wk[W-2:0], 1'b0};
            if (t >= dv) begin
                rem   = DW'(t - dv);
                wk[0] = 1'b1;
            end else begin
                rem = t[DW-1:0];
            end
        end
        n_work = wk;
        n_rem  = rem;
    end

    assign emit_idx = r_dcnt - CW'(1);

    // Status to the controller
    always_comb begin
        o_sts.in_dec    = (i_in_data.operation == icrc_pkg::OP_DECODE);
        o_sts.in_last   = i_in_data.last_char;
        o_sts.job_dec   = r_job_dec;
        o_sts.work_zero = (r_work == '0);
        o_sts.dcnt_lim  = !r_job_dec && (r_dcnt == CW'(icrc_pkg::ROLE_DIGITS));
        o_sts.dcnt_one  = (r_dcnt == CW'(1));
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // Decode state: accumulate, saturate count, clear on last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
        end else if (i_cmd.load && i_in_data.operation == icrc_pkg::OP_DECODE) begin
            if (i_in_data.last_char) begin
                r_acc   <= '0;
                r_count <= '0;
            end else begin
                r_acc <= n_acc;
                if (r_count < CW'(icrc_pkg::MAX_CODE_CHARS)) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    // Work registers: dividend, remainder, reversal, digit count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rev     <= '0;
            r_dcnt    <= '0;
            r_job_dec <= (i_in_data.operation == icrc_pkg::OP_DECODE);
            if (i_in_data.operation == icrc_pkg::OP_DECODE) begin
                r_work <= n_acc >> icrc_pkg::SCRAMBLE_SHIFT;
            end else begin
                r_work <= W'(i_in_data.role_id);
            end
        end
        if (i_cmd.b62_start) begin
            r_work <= {r_rev[W-icrc_pkg::SCRAMBLE_SHIFT-1:0], {icrc_pkg::SCRAMBLE_SHIFT{1'b0}}};
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
        if (i_cmd.rev_acc) begin
            r_rev  <= (r_rev << 3) + (r_rev << 1) + RW'(r_rem);
            r_dcnt <= r_dcnt + CW'(1);
        end
        if (i_cmd.b62_store) begin
            r_buf[r_dcnt] <= r_rem;
            r_dcnt        <= r_dcnt + CW'(1);
        end
        if (i_cmd.emit) begin
            r_dcnt <= emit_idx;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.dec_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.result_kind <= icrc_pkg::KIND_CHAR;
            r_out.out_char    <= digit_to_ascii(r_buf[emit_idx]);
            r_out.decoded_id  <= '0;
            r_out.last        <= (r_dcnt == CW'(1));
        end else if (i_cmd.dec_out) begin
            r_out.result_kind <= icrc_pkg::KIND_ID;
            r_out.out_char    <= '0;
            r_out.decoded_id  <= r_rev;
            r_out.last        <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### src/invite_code_radix_codec.sv
// ----------------------------------------------------------------------------
// invite_code_radix_codec
// Base-62 invite code encoder and decoder with decimal-reversal scramble.
// ----------------------------------------------------------------------------
// One item at a time. A decode character that does not end a code is folded
// into the accumulator as it is taken. Each decimal digit of the reversal and
// each base-62 digit is split off on the shared constant divider, which splits
// 8 dividend bits a cycle over a 64-bit word; the code characters then leave
// one at a time as the output register frees. A final decode character runs
// the reversal and then loads the decoded identifier. The output register lets
// the next item in while the last result still waits.
`default_nettype none

module invite_code_radix_codec (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire icrc_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output icrc_pkg::t_out       o_out_data
);

    icrc_pkg::t_cmd cmd;
    icrc_pkg::t_sts sts;

    icrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    icrc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // A decoded identifier is always the final result of its run
    a_id_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == icrc_pkg::KIND_ID |-> o_out_data.last)
        else $error("decoded identifier without last");

    // A code character lies between '0' and 'z' and carries no identifier
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == icrc_pkg::KIND_CHAR |->
        (o_out_data.out_char >= 7'd48) && (o_out_data.out_char <= 7'd122)
        && (o_out_data.decoded_id == '0))
        else $error("code character out of range");

    // Once an encode item is taken, the block stalls further items while it builds the result
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.operation == icrc_pkg::OP_ENCODE) |=>
        o_in_stall)
        else $error("item accepted during encode");
`endif

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the invite code radix codec: encode and decode
// items are driven with random gaps and back-pressure, and every result is
// compared against a behavioral model of the codec kept in a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    // Scoreboard: codec model plus queue of expected results
    class codec_scoreboard;
        icrc_pkg::t_out pending_q[$];
        logic [63:0]    dec_acc;
        int             errors;
        int             last_count;

        function new();
            dec_acc    = '0;
            errors     = 0;
            last_count = 0;
        endfunction

        function logic [6:0] digit_char(logic [63:0] d);
            if (d < 10) return 7'(8'd48 + d);
            if (d < 36) return 7'(8'd97 + d - 10);
            return 7'(8'd65 + d - 36);
        endfunction

        function logic [63:0] char_digit(logic [7:0] c);
            if (c >= 8'd48 && c <= 8'd57) return 64'(c - 8'd48);
            if (c >= 8'd97 && c <= 8'd122) return 64'(c - 8'd97 + 10);
            if (c >= 8'd65 && c <= 8'd90) return 64'(c - 8'd65 + 36);
            return 64'd0;
        endfunction

        function logic [63:0] flip_decimal(logic [63:0] v, int max_digits);
            logic [63:0] r;
            r = '0;
            for (int i = 0; i < max_digits && v != 0; i++) begin
                r = r * 10 + v % 10;
                v = v / 10;
            end
            return r;
        endfunction

        // Note an accepted input item and queue what it yields
        function void note_input(icrc_pkg::t_in it);
            logic [63:0]    v;
            logic [63:0]    digs[16];
            int             n;
            icrc_pkg::t_out r;
            if (it.operation == icrc_pkg::OP_ENCODE) begin
                v = flip_decimal(64'(it.role_id), icrc_pkg::ROLE_DIGITS)
                    << icrc_pkg::SCRAMBLE_SHIFT;
                n = 0;
                do begin
                    digs[n] = v % 62;
                    v = v / 62;
                    n++;
                end while (v != 0 && n < 16);
                for (int k = 0; k < n; k++) begin
                    r.result_kind = icrc_pkg::KIND_CHAR;
                    r.out_char    = digit_char(digs[n - 1 - k]);
                    r.decoded_id  = '0;
                    r.last        = (k == n - 1);
                    pending_q.push_back(r);
                end
                last_count = n;
            end else begin
                last_count = 0;
                dec_acc = dec_acc * 62 + char_digit(it.code_char);
                if (it.last_char) begin
                    r.result_kind = icrc_pkg::KIND_ID;
                    r.out_char    = '0;
                    r.decoded_id  = 47'(flip_decimal(dec_acc >> icrc_pkg::SCRAMBLE_SHIFT, 20));
                    r.last        = 1'b1;
                    pending_q.push_back(r);
                    last_count = 1;
                    dec_acc = '0;
                end
            end
        endfunction

        // Check one accepted result against the oldest expectation
        function void check_result(icrc_pkg::t_out got);
            icrc_pkg::t_out exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.result_kind !== exp_r.result_kind) begin
                $display("%0t: result_kind exp %h got %h", $realtime,
                         exp_r.result_kind, got.result_kind);
                errors++;
            end
            if (got.out_char !== exp_r.out_char) begin
                $display("%0t: out_char exp %h got %h", $realtime,
                         exp_r.out_char, got.out_char);
                errors++;
            end
            if (got.decoded_id !== exp_r.decoded_id) begin
                $display("%0t: decoded_id exp %0d got %0d", $realtime,
                         exp_r.decoded_id, got.decoded_id);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $display("%0t: last exp %h got %h", $realtime, exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_stall;
    icrc_pkg::t_in  i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    icrc_pkg::t_out o_out_data;

    codec_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  cycle_count = 0;
    localparam int CYCLE_LIMIT = 400000;

    invite_code_radix_codec uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stall, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Send one item, holding it until accepted; valid stays up for the next one
    task automatic send_item(icrc_pkg::t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic send_encode(logic [43:0] id);
        icrc_pkg::t_in it;
        it = '0;
        it.operation = icrc_pkg::OP_ENCODE;
        it.role_id = id;
        it.code_char = 8'($urandom);
        it.last_char = 1'($urandom);
        send_item(it);
    endtask

    task automatic send_char(logic [7:0] c, logic fin);
        icrc_pkg::t_in it;
        it = '0;
        it.operation = icrc_pkg::OP_DECODE;
        it.role_id = 44'({$urandom, $urandom});
        it.code_char = c;
        it.last_char = fin;
        send_item(it);
    endtask

    function automatic logic [7:0] alpha_char();
        int d;
        d = $urandom_range(61);
        if (d < 10) return 8'(48 + d);
        if (d < 36) return 8'(97 + d - 10);
        return 8'(65 + d - 36);
    endfunction

    function automatic logic [43:0] rand_id();
        case ($urandom_range(3))
            0: return 44'($urandom_range(999));
            1: return 44'({$urandom, $urandom}) % 44'd10000000000000;
            2: return 44'({$urandom, $urandom});
            default: return 44'd9999999999999 - 44'($urandom_range(1000));
        endcase
    endfunction

    // Encode an id, then decode the code it would produce
    task automatic round_trip(logic [43:0] id);
        icrc_pkg::t_out chars[$];
        int             base;
        send_encode(id);
        base = sb.pending_q.size() - sb.last_count;
        for (int k = base; k < sb.pending_q.size(); k++) chars.push_back(sb.pending_q[k]);
        foreach (chars[k]) send_char({1'b0, chars[k].out_char}, chars[k].last);
    endtask

    task automatic random_phase(int count);
        int n;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: round_trip(rand_id());
                4, 5: send_encode(rand_id());
                6, 7: begin
                    n = $urandom_range(1, 14);
                    for (int j = 1; j < n; j++) send_char(alpha_char(), 1'b0);
                    send_char(alpha_char(), 1'b1);
                end
                default: send_char(8'($urandom), 1'($urandom_range(3) == 0));
            endcase
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes and special cases
        send_encode(44'd0);
        send_encode(44'd1);
        send_encode(44'd9999999999999);
        send_encode(44'hFFFFFFFFFFF);
        send_encode(44'd1000000000000);
        round_trip(44'd1234567890123);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(8'h7B, 1'b0);
        send_char(8'h5B, 1'b0);
        send_encode(44'd42);
        send_char(8'h5A, 1'b1);
        for (int j = 0; j < 14; j++) send_char(8'h7A, j == 13);

        // Random phases with changing idle patterns
        send_idle_pct = 7;  recv_idle_pct = 46;
        random_phase(11);
        // Hold off until everything outstanding has drained
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        send_idle_pct = 46; recv_idle_pct = 7;
        random_phase(11);
        send_idle_pct = 0;  recv_idle_pct = 0;
        random_phase(10);

        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
